// ===== sv/mopd_pkg.sv =====
// shared types and codes of the periodic dispatcher
package mopd_pkg;

	// request kinds
	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_ADD     = 3'd1;
	localparam logic [2:0] KIND_REMOVE  = 3'd2;
	localparam logic [2:0] KIND_CHANGE  = 3'd3;
	localparam logic [2:0] KIND_OUTCOME = 3'd4;
	localparam logic [2:0] KIND_STOP    = 3'd5;

	// response status codes
	localparam logic [2:0] RS_DISPATCH = 3'd0;
	localparam logic [2:0] RS_SLEEP    = 3'd1;
	localparam logic [2:0] RS_WAIT     = 3'd2;
	localparam logic [2:0] RS_EMPTY    = 3'd3;
	localparam logic [2:0] RS_HALTED   = 3'd4;
	localparam logic [2:0] RS_OK       = 3'd5;
	localparam logic [2:0] RS_NOTFOUND = 3'd6;
	localparam logic [2:0] RS_FULL     = 3'd7;

	typedef struct packed {
		logic [7:0]  ident;
		logic [30:0] period;
		logic [31:0] last_time;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_rd;
		logic shift_rd;
		logic publish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] kind;
		logic       halted;
		logic       empty;
		logic       scan_last;
		logic       pipe_busy;
		logic       shift_need;
		logic       shift_last;
		logic       out_free;
	} sts_t;

endpackage

// ===== sv/mopd_req_if.sv =====
// request channel: one word per table operation, tick or stop
interface mopd_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  task_id;
	logic [30:0] interval_ms;
	logic [31:0] now_ms;
	logic        keep_task;

	modport source (output valid, kind, task_id, interval_ms, now_ms, keep_task,
		input ready);
	modport sink (input valid, kind, task_id, interval_ms, now_ms, keep_task,
		output ready);
endinterface

// ===== sv/mopd_rsp_if.sv =====
// response channel: one word per request
interface mopd_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  dispatch_id;
	logic [31:0] sleep_ms;

	modport source (output valid, status, dispatch_id, sleep_ms, input ready);
	modport sink (input valid, status, dispatch_id, sleep_ms, output ready);
endinterface

// ===== sv/mopd_datapath.sv =====
// task table memory, scan pipeline, compaction and response register
module mopd_datapath #(
	parameter int MAX_TASKS   = 16,
	parameter int SLEEP_SLACK = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         kind,
	input  logic [7:0]         task_id,
	input  logic [30:0]        interval_ms,
	input  logic [31:0]        now_ms,
	input  logic               keep_task,
	input  mopd_pkg::ctl_t     ctl,
	output mopd_pkg::sts_t     sts,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [2:0]         status,
	output logic [7:0]         dispatch_id,
	output logic [31:0]        sleep_ms
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam logic signed [31:0] NEG_SLACK = 32'sd0 - 32'(SLEEP_SLACK);

	// captured request word
	logic [2:0]  kind_q;
	logic [7:0]  id_q;
	logic [30:0] per_q;
	logic [31:0] now_q;
	logic        keep_q;

	logic [CNT_W-1:0] count_q;
	logic             halted_q;

	mopd_pkg::entry_t entry_mem_q [MAX_TASKS];

	logic [CNT_W-1:0] scan_addr_q;
	logic [CNT_W-1:0] sh_addr_q;
	logic             wr_pend_q;
	logic [IDX_W-1:0] wr_addr_q;
	logic [IDX_W-1:0] rd_addr;

	// scan pipeline
	logic             v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	mopd_pkg::entry_t ent_s1;
	logic [7:0]       id_s2, id_s3;
	logic [30:0]      per_s2, per_s3;
	logic [31:0]      sum_s2;
	logic signed [31:0] late_s3;

	logic signed [31:0] best_late_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [7:0]         best_id_q;
	logic [30:0]        best_per_q;

	logic             found_q;
	logic [IDX_W-1:0] match_idx_q;
	mopd_pkg::entry_t match_ent_q;

	logic        rsp_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  dispatch_id_q;
	logic [31:0] sleep_ms_q;

	logic             full;
	logic             drop;
	logic             id_hit;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	mopd_pkg::entry_t mem_wd;
	logic [2:0]       res_status;
	logic [7:0]       res_id;
	logic [31:0]      res_sleep;
	logic             cnt_inc;
	logic             cnt_dec;

	assign full   = (count_q == CNT_W'(MAX_TASKS));
	assign drop   = (kind_q == mopd_pkg::KIND_REMOVE) ||
		((kind_q == mopd_pkg::KIND_OUTCOME) && !keep_q);
	assign id_hit = v_s1 && !found_q && (ent_s1.ident == id_q);
	assign rd_addr = ctl.shift_rd ? sh_addr_q[IDX_W-1:0] : scan_addr_q[IDX_W-1:0];

	assign sts.kind       = kind_q;
	assign sts.halted     = halted_q;
	assign sts.empty      = (count_q == '0);
	assign sts.scan_last  = (CNT_W'(scan_addr_q + CNT_W'(1)) == count_q);
	assign sts.pipe_busy  = v_s1 || v_s2 || v_s3;
	assign sts.shift_need = found_q && drop && (sh_addr_q < count_q);
	assign sts.shift_last = (CNT_W'(sh_addr_q + CNT_W'(1)) == count_q);
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

	// response word for the current request
	always_comb begin
		res_status = mopd_pkg::RS_OK;
		res_id     = 8'd0;
		res_sleep  = 32'd0;
		case (kind_q)
			mopd_pkg::KIND_TICK: begin
				if (halted_q) begin
					res_status = mopd_pkg::RS_HALTED;
				end else if (count_q == '0) begin
					res_status = mopd_pkg::RS_EMPTY;
				end else if (!best_late_q[31]) begin
					res_status = mopd_pkg::RS_DISPATCH;
					res_id     = best_id_q;
				end else if (best_late_q < NEG_SLACK) begin
					res_status = mopd_pkg::RS_SLEEP;
					res_sleep  = 32'd0 - best_late_q;
				end else begin
					res_status = mopd_pkg::RS_WAIT;
				end
			end
			mopd_pkg::KIND_ADD: begin
				if (full) begin
					res_status = mopd_pkg::RS_FULL;
				end
			end
			mopd_pkg::KIND_REMOVE, mopd_pkg::KIND_CHANGE, mopd_pkg::KIND_OUTCOME: begin
				if (!found_q) begin
					res_status = mopd_pkg::RS_NOTFOUND;
				end
			end
			default: begin
				res_status = mopd_pkg::RS_OK;
			end
		endcase
	end

	// single write port: compaction move, or the write that goes with the response
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wr_addr_q;
		mem_wd = ent_s1;
		if (wr_pend_q) begin
			mem_we = 1'b1;
		end else if (ctl.publish) begin
			case (kind_q)
				mopd_pkg::KIND_TICK: begin
					if (!halted_q && (count_q != '0) && !best_late_q[31]) begin
						mem_we = 1'b1;
						mem_wa = best_idx_q;
						mem_wd = '{ident: best_id_q, period: best_per_q, last_time: now_q};
					end
				end
				mopd_pkg::KIND_ADD: begin
					if (!full) begin
						mem_we = 1'b1;
						mem_wa = count_q[IDX_W-1:0];
						mem_wd = '{ident: id_q, period: per_q, last_time: now_q};
					end
				end
				mopd_pkg::KIND_CHANGE: begin
					if (found_q) begin
						mem_we = 1'b1;
						mem_wa = match_idx_q;
						mem_wd = '{ident: match_ent_q.ident, period: per_q,
							last_time: match_ent_q.last_time};
					end
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	assign cnt_inc = ctl.publish && (kind_q == mopd_pkg::KIND_ADD) && !full;
	assign cnt_dec = ctl.publish && found_q && drop;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_wa] <= mem_wd;
		end
		ent_s1 <= entry_mem_q[rd_addr];
		idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			halted_q    <= 1'b0;
			scan_addr_q <= '0;
			wr_pend_q   <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cnt_inc) begin
				count_q <= CNT_W'(count_q + CNT_W'(1));
			end else if (cnt_dec) begin
				count_q <= CNT_W'(count_q - CNT_W'(1));
			end
			if (ctl.publish && (kind_q == mopd_pkg::KIND_STOP)) begin
				halted_q <= 1'b1;
			end
			if (ctl.load) begin
				scan_addr_q <= '0;
			end else if (ctl.scan_rd) begin
				scan_addr_q <= CNT_W'(scan_addr_q + CNT_W'(1));
			end
			if (ctl.load) begin
				found_q <= 1'b0;
			end else if (id_hit) begin
				found_q <= 1'b1;
			end
			wr_pend_q <= ctl.shift_rd;
			v_s1      <= ctl.scan_rd;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			if (ctl.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q <= kind;
			id_q   <= task_id;
			per_q  <= interval_ms;
			now_q  <= now_ms;
			keep_q <= keep_task;
		end
		// first entry with the requested id
		if (id_hit) begin
			match_idx_q <= idx_s1;
			match_ent_q <= ent_s1;
			sh_addr_q   <= CNT_W'(CNT_W'(idx_s1) + CNT_W'(1));
		end else if (ctl.shift_rd) begin
			sh_addr_q <= CNT_W'(sh_addr_q + CNT_W'(1));
		end
		if (ctl.shift_rd) begin
			wr_addr_q <= IDX_W'(sh_addr_q - CNT_W'(1));
		end
		idx_s2  <= idx_s1;
		id_s2   <= ent_s1.ident;
		per_s2  <= ent_s1.period;
		sum_s2  <= ent_s1.last_time + {1'b0, ent_s1.period};
		idx_s3  <= idx_s2;
		id_s3   <= id_s2;
		per_s3  <= per_s2;
		late_s3 <= now_q - sum_s2;
		// strictly later wins, first entry seeds the search
		if (v_s3 && ((idx_s3 == '0) || (late_s3 > best_late_q))) begin
			best_late_q <= late_s3;
			best_idx_q  <= idx_s3;
			best_id_q   <= id_s3;
			best_per_q  <= per_s3;
		end
		if (ctl.publish) begin
			status_q      <= res_status;
			dispatch_id_q <= res_id;
			sleep_ms_q    <= res_sleep;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign dispatch_id = dispatch_id_q;
	assign sleep_ms    = sleep_ms_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TASKS))
		else $error("task count beyond table size");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted cleared without reset");
	a_scan_vs_move: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && wr_pend_q))
		else $error("scan read overlaps compaction move");
	a_count_on_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(ctl.publish))
		else $error("task count changed outside a response");
`endif

endmodule

// ===== sv/mopd_ctrl.sv =====
// sequencer for request capture, table scan, compaction and response
module mopd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mopd_pkg::sts_t sts,
	output mopd_pkg::ctl_t ctl
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_SCAN   = 6'b000100,
		S_FLUSH  = 6'b001000,
		S_SHIFT  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   need_scan;

	assign need_scan = !sts.empty && (
		((sts.kind == mopd_pkg::KIND_TICK) && !sts.halted) ||
		(sts.kind == mopd_pkg::KIND_REMOVE) ||
		(sts.kind == mopd_pkg::KIND_CHANGE) ||
		(sts.kind == mopd_pkg::KIND_OUTCOME));

	assign req_ready    = (state_q == S_IDLE);
	assign ctl.load     = req_valid && req_ready;
	assign ctl.scan_rd  = (state_q == S_SCAN);
	assign ctl.shift_rd = (state_q == S_SHIFT);
	assign ctl.publish  = (state_q == S_DONE) && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (ctl.load) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = need_scan ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				if (sts.scan_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!sts.pipe_busy) begin
					state_d = sts.shift_need ? S_SHIFT : S_DONE;
				end
			end
			S_SHIFT: begin
				if (sts.shift_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !sts.pipe_busy)
		else $error("scan pipeline active while idle");
`endif

endmodule

// ===== sv/most_overdue_periodic_dispatcher.sv =====
// top level of the most-overdue-first periodic task dispatcher
// Keeps a table of up to MAX_TASKS periodic tasks and answers every request word
// with exactly one response word. Add, stop, the unused kinds, a refused tick, a
// tick on an empty table and a lookup on an empty table go from the decide state
// straight to the done state, which registers the response. Tick, remove, change
// interval and outcome otherwise read the table one entry per cycle through its
// single read port, then drain a three-stage lateness pipeline before the done
// state. A removal, or an outcome that drops its task, then moves every later
// entry up one place, one entry per cycle. One request is in work at a time; the
// next request can be accepted in the first cycle that the previous response is
// raised, and its own response waits until the response channel has taken that
// one. The table needs no clearing after reset.
module most_overdue_periodic_dispatcher #(
	parameter int MAX_TASKS   = 16,
	parameter int SLEEP_SLACK = 5
) (
	input logic        clk,
	input logic        arst_n,
	mopd_req_if.sink   req,
	mopd_rsp_if.source rsp
);

	mopd_pkg::ctl_t ctl;
	mopd_pkg::sts_t sts;

	mopd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	mopd_datapath #(
		.MAX_TASKS   (MAX_TASKS),
		.SLEEP_SLACK (SLEEP_SLACK)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (req.kind),
		.task_id     (req.task_id),
		.interval_ms (req.interval_ms),
		.now_ms      (req.now_ms),
		.keep_task   (req.keep_task),
		.ctl         (ctl),
		.sts         (sts),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.status      (rsp.status),
		.dispatch_id (rsp.dispatch_id),
		.sleep_ms    (rsp.sleep_ms)
	);

endmodule

// ===== tb/sv/mopd_tb_pkg.sv =====
`timescale 1ns / 100ps
// scoreboard of the periodic dispatcher testbench: table predictor and response checks
package mopd_tb_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int SLACK_MS    = 5;

	// kinds with no operation behind them
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  dispatch_id;
		logic [31:0] sleep_ms;
	} rsp_word_t;

	class dispatch_scoreboard;
		int unsigned entry_count;
		logic [7:0]  entry_ident [TABLE_DEPTH];
		logic [30:0] entry_period [TABLE_DEPTH];
		logic [31:0] entry_last_time [TABLE_DEPTH];
		bit          halted;
		rsp_word_t   expected_rsp [$];
		int unsigned mismatches;
		int unsigned words_in;
		int unsigned words_out;
		int unsigned status_seen [8];

		function new();
			entry_count = 0;
			halted = 0;
			mismatches = 0;
			words_in = 0;
			words_out = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function int find_task(logic [7:0] id);
			for (int k = 0; k < entry_count; k++)
				if (entry_ident[k] == id) return k;
			return -1;
		endfunction

		function void drop_task(int pos);
			for (int k = pos; k + 1 < entry_count; k++) begin
				entry_ident[k] = entry_ident[k + 1];
				entry_period[k] = entry_period[k + 1];
				entry_last_time[k] = entry_last_time[k + 1];
			end
			entry_count--;
		endfunction

		function rsp_word_t predict_response(logic [2:0] kind, logic [7:0] id,
			logic [30:0] interval, logic [31:0] now, logic keep);
			rsp_word_t r;
			int pos;
			int best;
			logic [31:0] diff;
			longint late;
			longint best_late;
			r.status = mopd_pkg::RS_OK;
			r.dispatch_id = '0;
			r.sleep_ms = '0;
			best = 0;
			best_late = 0;
			case (kind)
				mopd_pkg::KIND_TICK: begin
					if (halted) begin
						r.status = mopd_pkg::RS_HALTED;
					end else if (entry_count == 0) begin
						r.status = mopd_pkg::RS_EMPTY;
					end else begin
						for (int k = 0; k < entry_count; k++) begin
							diff = now - (entry_last_time[k] + 32'(entry_period[k]));
							late = $signed(diff);
							if (k == 0 || late > best_late) begin
								best_late = late;
								best = k;
							end
						end
						if (best_late >= 0) begin
							r.status = mopd_pkg::RS_DISPATCH;
							r.dispatch_id = entry_ident[best];
							entry_last_time[best] = now;
						end else if (best_late < -SLACK_MS) begin
							r.status = mopd_pkg::RS_SLEEP;
							r.sleep_ms = 32'(-best_late);
						end else begin
							r.status = mopd_pkg::RS_WAIT;
						end
					end
				end
				mopd_pkg::KIND_ADD: begin
					if (entry_count >= TABLE_DEPTH) begin
						r.status = mopd_pkg::RS_FULL;
					end else begin
						entry_ident[entry_count] = id;
						entry_period[entry_count] = interval;
						entry_last_time[entry_count] = now;
						entry_count++;
					end
				end
				mopd_pkg::KIND_REMOVE: begin
					pos = find_task(id);
					if (pos < 0) r.status = mopd_pkg::RS_NOTFOUND;
					else drop_task(pos);
				end
				mopd_pkg::KIND_CHANGE: begin
					pos = find_task(id);
					if (pos < 0) r.status = mopd_pkg::RS_NOTFOUND;
					else entry_period[pos] = interval;
				end
				mopd_pkg::KIND_OUTCOME: begin
					pos = find_task(id);
					if (pos < 0) r.status = mopd_pkg::RS_NOTFOUND;
					else if (!keep) drop_task(pos);
				end
				mopd_pkg::KIND_STOP: begin
					halted = 1;
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void note_request(logic [2:0] kind, logic [7:0] id, logic [30:0] interval,
			logic [31:0] now, logic keep);
			words_in++;
			expected_rsp.insert(expected_rsp.size(),
				predict_response(kind, id, interval, now, keep));
		endfunction

		function void check_response(logic [2:0] status, logic [7:0] id, logic [31:0] sleep);
			rsp_word_t exp_word;
			words_out++;
			status_seen[status]++;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response word status %0d id %0d sleep %0d",
					$time, status, id, sleep);
				return;
			end
			exp_word = expected_rsp.pop_front();
			if (status !== exp_word.status) begin
				mismatches++;
				$display("%0t: status expected %0d actual %0d", $time, exp_word.status, status);
			end
			if (id !== exp_word.dispatch_id) begin
				mismatches++;
				$display("%0t: dispatch_id expected %0d actual %0d",
					$time, exp_word.dispatch_id, id);
			end
			if (sleep !== exp_word.sleep_ms) begin
				mismatches++;
				$display("%0t: sleep_ms expected %0d actual %0d", $time, exp_word.sleep_ms, sleep);
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// top-level testbench of the most-overdue-first periodic dispatcher
module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mopd_req_if req_ch ();
	mopd_rsp_if rsp_ch ();

	most_overdue_periodic_dispatcher DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mopd_tb_pkg::dispatch_scoreboard sb = new();

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_serial = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	logic [31:0] clock_ms = '0;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.kind = mopd_pkg::KIND_TICK;
		req_ch.task_id = '0;
		req_ch.interval_ms = '0;
		req_ch.now_ms = '0;
		req_ch.keep_task = 1'b0;
		rsp_ch.ready = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, sb.expected_rsp.size());
			$display("status: fail");
			$finish;
		end
	end

	// receiver with random stalls and one long hold-off on request
	always @(negedge clk) begin
		if (hold_serial != hold_seen) begin
			hold_seen = hold_serial;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready = 1'b0;
		end else begin
			rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.kind, req_ch.task_id, req_ch.interval_ms,
					req_ch.now_ms, req_ch.keep_task);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.status, rsp_ch.dispatch_id, rsp_ch.sleep_ms);
		end
	end

	task automatic send_word(logic [2:0] kind, logic [7:0] id, logic [30:0] interval,
		logic [31:0] now, logic keep);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.kind = kind;
		req_ch.task_id = id;
		req_ch.interval_ms = interval;
		req_ch.now_ms = now;
		req_ch.keep_task = keep;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_word();
		int unsigned pick;
		int unsigned k;
		logic [2:0]  kind;
		logic [7:0]  id;
		logic [30:0] interval;
		logic [31:0] now;
		pick = $urandom_range(99);
		if (pick < 45) kind = mopd_pkg::KIND_TICK;
		else if (pick < 65) kind = mopd_pkg::KIND_ADD;
		else if (pick < 75) kind = mopd_pkg::KIND_REMOVE;
		else if (pick < 84) kind = mopd_pkg::KIND_CHANGE;
		else if (pick < 95) kind = mopd_pkg::KIND_OUTCOME;
		else if (pick < 97) kind = mopd_tb_pkg::KIND_SPARE_6;
		else kind = mopd_tb_pkg::KIND_SPARE_7;

		if (sb.entry_count != 0 && $urandom_range(3) != 0)
			id = sb.entry_ident[$urandom_range(sb.entry_count - 1)];
		else if ($urandom_range(1) != 0)
			id = 8'($urandom_range(15));
		else
			id = 8'($urandom_range(255));

		pick = $urandom_range(99);
		if (pick < 80) interval = 31'($urandom_range(300));
		else if (pick < 90) interval = 31'($urandom);
		else interval = 31'($urandom_range(3));

		clock_ms = clock_ms + 32'($urandom_range(40));
		pick = $urandom_range(99);
		if (pick < 50) begin
			now = clock_ms;
		end else if (pick < 80 && sb.entry_count != 0) begin
			// close to a deadline: dispatch, short wait or just past the slack
			k = $urandom_range(sb.entry_count - 1);
			now = sb.entry_last_time[k] + 32'(sb.entry_period[k])
				+ 32'($urandom_range(11)) - 32'd8;
		end else begin
			now = $urandom;
		end
		send_word(kind, id, interval, now, 1'($urandom_range(1)));
	endtask

	task automatic fill_table();
		while (sb.entry_count < mopd_tb_pkg::TABLE_DEPTH)
			send_word(mopd_pkg::KIND_ADD, 8'($urandom_range(255)), 31'($urandom_range(200)),
				clock_ms, 1'b0);
		send_word(mopd_pkg::KIND_ADD, 8'($urandom_range(255)), 31'($urandom), $urandom, 1'b1);
		send_word(mopd_pkg::KIND_TICK, 8'd0, 31'd0, clock_ms, 1'b0);
	endtask

	int unsigned phase_send [4] = '{0, 78, 0, 30};
	int unsigned phase_recv [4] = '{0, 0, 78, 30};

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(mopd_pkg::KIND_TICK, 8'd0, 31'd0, 32'd0, 1'b0);
		send_word(mopd_pkg::KIND_REMOVE, 8'd7, 31'd0, 32'd0, 1'b0);
		send_word(mopd_pkg::KIND_CHANGE, 8'd7, 31'd9, 32'd0, 1'b0);
		send_word(mopd_pkg::KIND_OUTCOME, 8'd7, 31'd0, 32'd0, 1'b1);
		send_word(mopd_pkg::KIND_ADD, 8'd0, 31'h7fff_ffff, 32'd0, 1'b0);
		send_word(mopd_pkg::KIND_TICK, 8'd0, 31'd0, 32'hffff_ffff, 1'b0);
		send_word(mopd_pkg::KIND_TICK, 8'd0, 31'd0, 32'h7fff_ffff, 1'b0);
		send_word(mopd_pkg::KIND_CHANGE, 8'd0, 31'd100, 32'd0, 1'b0);
		send_word(mopd_pkg::KIND_TICK, 8'd0, 31'd0, 32'h7fff_ffff + 32'd95, 1'b0);
		send_word(mopd_pkg::KIND_TICK, 8'd0, 31'd0, 32'h7fff_ffff + 32'd94, 1'b0);
		send_word(mopd_pkg::KIND_REMOVE, 8'd0, 31'd0, 32'd0, 1'b0);
		send_word(mopd_pkg::KIND_ADD, 8'd255, 31'd0, 32'hffff_ffff, 1'b0);
		send_word(mopd_pkg::KIND_ADD, 8'd254, 31'd0, 32'hffff_ffff, 1'b0);
		// equal lateness on both entries
		send_word(mopd_pkg::KIND_TICK, 8'd0, 31'd0, 32'hffff_ffff, 1'b0);
		send_word(mopd_pkg::KIND_ADD, 8'd255, 31'd10, 32'd5, 1'b0);
		send_word(mopd_pkg::KIND_OUTCOME, 8'd255, 31'd0, 32'd0, 1'b1);
		send_word(mopd_pkg::KIND_OUTCOME, 8'd255, 31'd0, 32'd0, 1'b0);
		send_word(mopd_tb_pkg::KIND_SPARE_6, 8'd255, 31'h7fff_ffff, 32'hffff_ffff, 1'b1);
		send_word(mopd_tb_pkg::KIND_SPARE_7, 8'd0, 31'd0, 32'd0, 1'b0);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_send[p];
			recv_stall_pct = phase_recv[p];
			clock_ms = (p == 2) ? 32'hffff_f000 : $urandom;
			if (p == 0) hold_serial++;
			repeat (160) begin
				if ($urandom_range(49) == 0) fill_table();
				else send_random_word();
			end
		end

		// halt is sticky, so stop comes last
		send_idle_pct = 30;
		recv_stall_pct = 30;
		send_word(mopd_pkg::KIND_STOP, 8'd0, 31'd0, 32'd0, 1'b0);
		send_word(mopd_pkg::KIND_TICK, 8'd0, 31'd0, clock_ms, 1'b0);
		repeat (20) send_random_word();
		req_ch.valid = 1'b0;

		recv_stall_pct = 0;
		while (sb.expected_rsp.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("sent %0d request words, checked %0d response words, %0d mismatches",
			sb.words_in, sb.words_out, sb.mismatches);
		$display("dispatch %0d sleep %0d wait %0d empty %0d halted %0d ok %0d missing %0d full %0d",
			sb.status_seen[mopd_pkg::RS_DISPATCH], sb.status_seen[mopd_pkg::RS_SLEEP],
			sb.status_seen[mopd_pkg::RS_WAIT], sb.status_seen[mopd_pkg::RS_EMPTY],
			sb.status_seen[mopd_pkg::RS_HALTED], sb.status_seen[mopd_pkg::RS_OK],
			sb.status_seen[mopd_pkg::RS_NOTFOUND], sb.status_seen[mopd_pkg::RS_FULL]);
		if (sb.mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/mopd_pkg.sv
sv/mopd_req_if.sv
sv/mopd_rsp_if.sv
sv/mopd_datapath.sv
sv/mopd_ctrl.sv
sv/most_overdue_periodic_dispatcher.sv
tb/sv/mopd_tb_pkg.sv
tb/sv/testbench.sv
